FILE: sv/hbkr_pkg.sv
package hbkr_pkg;

  localparam int MOD_BITS  = 8;
  localparam int KEY_SLOTS = 6;
  localparam int NUM_EV    = MOD_BITS + 2 * KEY_SLOTS;
  localparam int EV_IDX_W  = $clog2(NUM_EV);

  localparam logic [7:0] MOD_USAGE_BASE = 8'hE0;
  localparam logic [7:0] MIN_USAGE      = 8'h04;
  localparam logic [7:0] SKIP_USAGE     = 8'h32;
  localparam logic [7:0] MAX_USAGE      = 8'h65;

  // Byte offsets inside the boot report
  localparam int MOD_BYTE  = 0;
  localparam int KEY_BYTE0 = 2;

  typedef logic [KEY_SLOTS-1:0][7:0] key_slots_t;

  // One event candidate per lane: modifiers first, then presses, then releases
  typedef struct packed {
    logic [NUM_EV-1:0]       hit;
    logic [NUM_EV-1:0]       rel;
    logic [NUM_EV-1:0][7:0]  code;
  } ev_set_t;

  function automatic logic usage_reported(input logic [7:0] u);
    usage_reported = (u >= MIN_USAGE) && (u != SKIP_USAGE) && (u <= MAX_USAGE);
  endfunction

endpackage

FILE: sv/hbkr_key_lane.sv
module hbkr_key_lane (
  input  logic [7:0]          slot_code,
  input  logic                scan_en,
  input  hbkr_pkg::key_slots_t other,
  output logic                hit
);
  import hbkr_pkg::*;

  logic found;

  // Membership over all six slots of the other report, zero slots included
  always_comb begin
    found = 1'b0;
    for (int s = 0; s < KEY_SLOTS; s++) begin
      if (other[s] == slot_code) begin
        found = 1'b1;
      end
    end
  end

  assign hit = scan_en && !found && usage_reported(slot_code);

endmodule

FILE: sv/hbkr_merge.sv
module hbkr_merge (
  input  logic              clk,
  input  logic              rst_n,
  input  hbkr_pkg::ev_set_t new_set,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_code,
  output logic              out_rel,
  output logic              out_last
);
  import hbkr_pkg::*;

  logic [NUM_EV-1:0]      pend_r, pend_nxt;
  logic [NUM_EV-1:0]      rel_r;
  logic [NUM_EV-1:0][7:0] code_r;
  logic [NUM_EV-1:0]      low_bit;
  logic [NUM_EV-1:0]      pend_rest;
  logic [7:0]             code_sel;
  logic                   rel_sel;
  logic                   out_load;
  logic                   accept;

  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_code_r;
  logic                   out_rel_r;
  logic                   out_last_r;

  assign low_bit   = pend_r & (~pend_r + NUM_EV'(1));
  assign pend_rest = pend_r & ~low_bit;

  always_comb begin
    code_sel = '0;
    rel_sel  = 1'b0;
    for (int i = 0; i < NUM_EV; i++) begin
      if (low_bit[i]) begin
        code_sel = code_sel | code_r[i];
        rel_sel  = rel_sel | rel_r[i];
      end
    end
  end

  assign out_load  = (!out_valid_r || out_tready) && (pend_r != '0);
  assign in_tready = (pend_r == '0) || ((pend_rest == '0) && out_load);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    if (accept) begin
      pend_nxt = new_set.hit;
    end else if (out_load) begin
      pend_nxt = pend_rest;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rel_r  <= new_set.rel;
      code_r <= new_set.code;
    end
    if (out_load) begin
      out_code_r <= code_sel;
      out_rel_r  <= rel_sel;
      out_last_r <= (pend_rest == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_code   = out_code_r;
  assign out_rel    = out_rel_r;
  assign out_last   = out_last_r;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (pend_rest == '0))
    else $error("pending events overwritten by new report");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("loaded event not presented");

  a_one_per_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !accept) |=> ($countones(pend_r) == $countones($past(pend_r)) - 1))
    else $error("pending count did not drop by one");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (pend_rest == '0) && !accept) |=> (pend_r == '0))
    else $error("events left after final event");
`endif

endmodule

FILE: sv/hid_boot_keyboard_report_diff.sv
// Boot keyboard report differ. Each 8-byte report transferred in on the
// in_ side is compared with the report before it (zero after reset) and
// turned into key events on the out_ side: changed modifier bits first (usage
// 0xE0 plus bit number, released = old bit value), then newly pressed keys
// in slot order, then released keys in slot order. A key scan stops at the
// first zero slot; usages 1..3, 0x32 and above 0x65 are skipped. twenty
// lanes find all candidate events of a report at once and a merge stage
// drains them through an output register, one per cycle unless out_tready
// stalls it, marking the final event with out_tlast. A report that changes
// nothing produces no transfer. The next report is taken in the same cycle
// the previous report's final event moves to the output register, and a
// report yields up to 20 events, so the event drain sets the pace.
module hid_boot_keyboard_report_diff (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] report
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] usage_code
  output logic        out_tuser,  // [0] released
  output logic        out_tlast   // last_event
);
  import hbkr_pkg::*;

  logic [63:0]  prev_r;
  key_slots_t   cur_keys, prev_keys;
  logic [7:0]   cur_mod, prev_mod;
  logic [KEY_SLOTS-1:0] cur_en, prev_en;
  logic [KEY_SLOTS-1:0] press_hit, rel_hit;
  ev_set_t      ev_set;

  assign cur_mod  = in_tdata[8*MOD_BYTE +: 8];
  assign prev_mod = prev_r[8*MOD_BYTE +: 8];

  always_comb begin
    for (int s = 0; s < KEY_SLOTS; s++) begin
      cur_keys[s]  = in_tdata[8*(KEY_BYTE0+s) +: 8];
      prev_keys[s] = prev_r[8*(KEY_BYTE0+s) +: 8];
    end
  end

  // Scan stops at the first empty slot: a slot counts only if every slot up
  // to and including it is nonzero
  always_comb begin
    cur_en[0]  = (cur_keys[0] != '0);
    prev_en[0] = (prev_keys[0] != '0);
    for (int s = 1; s < KEY_SLOTS; s++) begin
      cur_en[s]  = cur_en[s-1] && (cur_keys[s] != '0);
      prev_en[s] = prev_en[s-1] && (prev_keys[s] != '0);
    end
  end

  // Press lanes check current slots against the old report, release lanes
  // check old slots against the current report
  for (genvar s = 0; s < KEY_SLOTS; s++) begin : g_keys
    hbkr_key_lane u_press (
      .slot_code (cur_keys[s]),
      .scan_en   (cur_en[s]),
      .other     (prev_keys),
      .hit       (press_hit[s])
    );
    hbkr_key_lane u_release (
      .slot_code (prev_keys[s]),
      .scan_en   (prev_en[s]),
      .other     (cur_keys),
      .hit       (rel_hit[s])
    );
  end

  // Pack lanes in event order
  always_comb begin
    for (int i = 0; i < MOD_BITS; i++) begin
      ev_set.hit[i]  = cur_mod[i] ^ prev_mod[i];
      ev_set.rel[i]  = prev_mod[i];
      ev_set.code[i] = MOD_USAGE_BASE | 8'(i);
    end
    for (int s = 0; s < KEY_SLOTS; s++) begin
      ev_set.hit[MOD_BITS+s]            = press_hit[s];
      ev_set.rel[MOD_BITS+s]            = 1'b0;
      ev_set.code[MOD_BITS+s]           = cur_keys[s];
      ev_set.hit[MOD_BITS+KEY_SLOTS+s]  = rel_hit[s];
      ev_set.rel[MOD_BITS+KEY_SLOTS+s]  = 1'b1;
      ev_set.code[MOD_BITS+KEY_SLOTS+s] = prev_keys[s];
    end
  end

  hbkr_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .new_set    (ev_set),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_code   (out_tdata),
    .out_rel    (out_tuser),
    .out_last   (out_tlast)
  );

  // Hold the report of every transfer as the reference for the next one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (in_tvalid && in_tready) begin
      prev_r <= in_tdata;
    end
  end

endmodule
